// ===== sv/msk_nco_modulator_assert.svh =====
// Assertion helpers for the MSK modulator; clk and rst are taken from the including scope.
`ifndef MSK_NCO_MODULATOR_ASSERT_SVH
`define MSK_NCO_MODULATOR_ASSERT_SVH

// Same-cycle implication.
`define MSK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("msk_nco_modulator: check failed");

// Next-cycle implication.
`define MSK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("msk_nco_modulator: check failed");

`endif

// ===== sv/msk_pkg.sv =====
package msk_pkg;

  localparam int SINE_ADDR_BITS = 10;
  localparam int PHASE_BITS     = 32;
  localparam int BYTE_BITS      = 8;

  localparam int QUARTER_BITS = SINE_ADDR_BITS - 2;
  localparam int QUARTER      = 1 << QUARTER_BITS;
  localparam int STEP_W       = (PHASE_BITS > 32) ? PHASE_BITS : 33;
  localparam int BITS_W       = $clog2(BYTE_BITS + 1);

  localparam int REG_W    = 32;
  localparam int DEV_W    = 31;
  localparam int RAB_W    = 24;
  localparam int COUNT_W  = 25;
  localparam int MAG_W    = 15;
  localparam int SAMPLE_W = 15;
  localparam int INDEX_W  = 2;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [INDEX_W-1:0] {
    REG_CARRIER,
    REG_DEVIATION,
    REG_SYMBOL,
    REG_READY_AFTER
  } reg_index_t;

  // Q15 magnitude of sin(j * (pi/2) / QUARTER), Taylor series to x^13 in Q30.
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] m;
    x    = (64'(j) * HALF_PI_Q30) >> QUARTER_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 6; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        default: term = term / 64'd156;
      endcase
      if ((n & 1) != 0) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    m = sum >> 15;
    if (m > 64'd32767) begin
      m = 64'd32767;
    end
    return m[MAG_W-1:0];
  endfunction

  typedef logic [QUARTER-1:0][MAG_W-1:0] qsine_tab_t;

  function automatic qsine_tab_t build_qsine();
    qsine_tab_t t;
    for (int k = 0; k < QUARTER; k++) begin
      t[k] = quarter_sine(k);
    end
    return t;
  endfunction

  localparam qsine_tab_t       QSINE      = build_qsine();
  localparam logic [MAG_W-1:0] QSINE_PEAK = quarter_sine(QUARTER);

  // Register value taken modulo 2^PHASE_BITS.
  function automatic logic [PHASE_BITS-1:0] to_phase(input logic [REG_W-1:0] v);
    logic [STEP_W-1:0] w;
    w = STEP_W'(v);
    return w[PHASE_BITS-1:0];
  endfunction

endpackage

// ===== sv/msk_if.sv =====
interface msk_byte_if import msk_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] byte_in;
  logic                 byte_present;

  modport source (output valid, byte_in, byte_present, input ready);
  modport sink   (input valid, byte_in, byte_present, output ready);
endinterface

interface msk_sample_if import msk_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       byte_taken;
  logic                       ready_pulse;

  modport source (output valid, sample, byte_taken, ready_pulse, input ready);
  modport sink   (input valid, sample, byte_taken, ready_pulse, output ready);
endinterface

// ===== sv/msk_nco_modulator.sv =====
// The result is loaded into the output register on the edge of its input transfer and is
// valid from the next cycle on.
// Throughput: one item per cycle while samples.ready does not stall the output.
// A new transfer is taken while the held result is being taken.
// Reset (rst, synchronous): registers, phase words, bit state and counters clear to zero.
module msk_nco_modulator import msk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [INDEX_W-1:0] wr_index,
  input  logic [REG_W-1:0]   wr_data,
  msk_byte_if.sink           bytes,
  msk_sample_if.source       samples
);

  logic [REG_W-1:0] carrier_step;
  logic [DEV_W-1:0] deviation_step;
  logic [REG_W-1:0] symbol_step;
  logic [RAB_W-1:0] ready_after_bits;

  logic [PHASE_BITS-1:0] osc_phase;
  logic [PHASE_BITS-1:0] osc_increment;
  logic [PHASE_BITS-1:0] symbol_phase;
  logic [BYTE_BITS-1:0]  bit_shift;
  logic [BITS_W-1:0]     bits_remaining;
  logic [COUNT_W-1:0]    sent_bit_count;

  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       taken_q;
  logic                       pulse_q;

  logic                      accept;
  logic [SINE_ADDR_BITS-1:0] addr;
  logic [1:0]                quad;
  logic [QUARTER_BITS-1:0]   r;
  logic [QUARTER_BITS-1:0]   mirror_idx;
  logic [MAG_W-1:0]          mag;
  logic [MAG_W-1:0]          half;
  logic [SAMPLE_W-1:0]       sample_next;

  logic [PHASE_BITS:0]     sym_sum;
  logic                    boundary;
  logic                    refill;
  logic [BYTE_BITS-1:0]    shift_src;
  logic [BYTE_BITS-1:0]    bit_shift_next;
  logic [BITS_W-1:0]       bits_remaining_next;
  logic                    taken;
  logic                    count_ok;
  logic                    ready_flag;
  logic [STEP_W-1:0]       step_up;
  logic [STEP_W-1:0]       step_dn;
  logic [PHASE_BITS-1:0]   inc_sel;
  logic [PHASE_BITS-1:0]   osc_increment_next;

  assign bytes.ready = !out_valid || samples.ready;
  assign accept      = bytes.valid && bytes.ready;

  // Quarter-wave lookup: odd quadrants mirror, upper half negates.
  assign addr       = osc_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign quad       = addr[SINE_ADDR_BITS-1 -: 2];
  assign r          = addr[QUARTER_BITS-1:0];
  assign mirror_idx = ~r + 1'b1;

  always_comb begin
    if (quad[0]) begin
      mag = (r == '0) ? QSINE_PEAK : QSINE[mirror_idx];
    end else begin
      mag = QSINE[r];
    end
  end

  assign half        = mag >> 1;
  assign sample_next = quad[1] ? (~SAMPLE_W'(half) + 1'b1) : SAMPLE_W'(half);

  // Bit boundary is the carry out of the symbol accumulator.
  assign sym_sum  = {1'b0, symbol_phase} + {1'b0, to_phase(symbol_step)};
  assign boundary = sym_sum[PHASE_BITS];
  assign refill   = (bits_remaining == '0);

  always_comb begin
    if (refill) begin
      shift_src = bytes.byte_present ? bytes.byte_in : '0;
    end else begin
      shift_src = bit_shift;
    end
  end

  assign taken               = boundary && refill && bytes.byte_present;
  assign bit_shift_next      = shift_src >> 1;
  assign bits_remaining_next = refill ? BITS_W'(BYTE_BITS - 1) : bits_remaining - 1'b1;

  assign count_ok   = (sent_bit_count <= COUNT_W'(ready_after_bits));
  assign ready_flag = boundary && (sent_bit_count == COUNT_W'(ready_after_bits));

  assign step_up            = STEP_W'(carrier_step) + STEP_W'(deviation_step);
  assign step_dn            = STEP_W'(carrier_step) - STEP_W'(deviation_step);
  assign inc_sel            = shift_src[0] ? step_up[PHASE_BITS-1:0] : step_dn[PHASE_BITS-1:0];
  assign osc_increment_next = boundary ? inc_sel : osc_increment;

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_step     <= '0;
      deviation_step   <= '0;
      symbol_step      <= '0;
      ready_after_bits <= '0;
      osc_phase        <= '0;
      osc_increment    <= '0;
      symbol_phase     <= '0;
      bit_shift        <= '0;
      bits_remaining   <= '0;
      sent_bit_count   <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (wr_en) begin
        case (reg_index_t'(wr_index))
          REG_CARRIER: begin
            carrier_step  <= wr_data;
            osc_increment <= to_phase(wr_data);
          end
          REG_DEVIATION:   deviation_step   <= wr_data[DEV_W-1:0];
          REG_SYMBOL:      symbol_step      <= wr_data;
          REG_READY_AFTER: ready_after_bits <= wr_data[RAB_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        // new step applies to this tick's phase advance
        osc_phase    <= osc_phase + osc_increment_next;
        symbol_phase <= sym_sum[PHASE_BITS-1:0];
        if (boundary) begin
          osc_increment  <= inc_sel;
          bit_shift      <= bit_shift_next;
          bits_remaining <= bits_remaining_next;
          if (count_ok) begin
            sent_bit_count <= sent_bit_count + 1'b1;
          end
        end
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (samples.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= sample_next;
      taken_q  <= taken;
      pulse_q  <= ready_flag;
    end
  end

  assign samples.valid       = out_valid;
  assign samples.sample      = sample_q;
  assign samples.byte_taken  = taken_q;
  assign samples.ready_pulse = pulse_q;

`include "msk_nco_modulator_assert.svh"

  `MSK_ASSERT_NEXT(a_refill_count, accept && boundary && refill, bits_remaining == BITS_W'(BYTE_BITS - 1))
  `MSK_ASSERT_NEXT(a_step_holds, accept && !boundary && !wr_en, $stable(osc_increment))
  `MSK_ASSERT_NEXT(a_pulse_count, accept && ready_flag, sent_bit_count == COUNT_W'($past(ready_after_bits)) + 1'b1)
  `MSK_ASSERT_NOW(a_taken_needs_refill, accept && taken, refill && bytes.byte_present)

endmodule
